// ----- sv/nttbm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nttbm_pkg
// Constants, opcode type and modular helpers for the Montgomery NTT butterfly.
// ----------------------------------------------------------------------------
package nttbm_pkg;

	localparam int unsigned COEF_W = 31;

	localparam logic [COEF_W-1:0] QMOD    = 31'd2147352577;
	localparam logic [31:0]       QMOD_32 = 32'd2147352577;
	localparam logic [31:0]       QNEGINV = 32'h7FFD_FFFF;

	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [2*COEF_W-1:0] prod_t;

	typedef enum logic [1:0] {
		OP_FWD = 2'd0,
		OP_INV = 2'd1,
		OP_MUL = 2'd2,
		OP_MAC = 2'd3
	} op_t;

	// a + b mod q, both inputs below q
	function automatic coef_t mod_add(input coef_t a, input coef_t b);
		logic [31:0] s;
		logic [31:0] d;
		s = {1'b0, a} + {1'b0, b};
		d = s - QMOD_32;
		return d[31] ? s[COEF_W-1:0] : d[COEF_W-1:0];
	endfunction

	// a - b mod q, both inputs below q
	function automatic coef_t mod_sub(input coef_t a, input coef_t b);
		logic [31:0] d;
		logic [31:0] w;
		d = {1'b0, a} - {1'b0, b};
		w = d + QMOD_32;
		return d[31] ? w[COEF_W-1:0] : d[COEF_W-1:0];
	endfunction

	// final correction of a montgomery reduction, t below 1.5q
	function automatic coef_t mont_fix(input logic [31:0] t);
		logic [31:0] d;
		d = t - QMOD_32;
		return d[31] ? t[COEF_W-1:0] : d[COEF_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- sv/nttbm_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nttbm_in_if
// Operand channel of the Montgomery NTT butterfly: valid, ready and operands.
// ----------------------------------------------------------------------------
interface nttbm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [30:0] first_operand;
	logic [30:0] second_operand;
	logic [30:0] third_operand;
	logic [30:0] fourth_operand;

	modport source (
		output valid, opcode, first_operand, second_operand, third_operand,
			fourth_operand,
		input  ready
	);

	modport sink (
		input  valid, opcode, first_operand, second_operand, third_operand,
			fourth_operand,
		output ready
	);
endinterface
`default_nettype wire

// ----- sv/nttbm_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nttbm_out_if
// Result channel of the Montgomery NTT butterfly: valid, ready and results.
// ----------------------------------------------------------------------------
interface nttbm_out_if;
	logic        valid;
	logic        ready;
	logic [30:0] first_result;
	logic [30:0] second_result;
	logic        range_error;

	modport source (
		output valid, first_result, second_result, range_error,
		input  ready
	);

	modport sink (
		input  valid, first_result, second_result, range_error,
		output ready
	);
endinterface
`default_nettype wire

// ----- sv/ntt_butterfly_montgomery_q31.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ntt_butterfly_montgomery_q31
// Modular butterfly unit for a negacyclic NTT over q = 2147352577, R = 2^32.
//
// item carries an opcode and four operands, result carries two residues and
// a range flag; one transaction in gives exactly one transaction out.
// Opcodes: forward CT butterfly, inverse GS butterfly, montgomery product,
// montgomery multiply-add. An operand in use at or above q gives range_error = 1
// and zero results.
// Throughput is one transaction per cycle while the receiver takes results:
// the seven register stages (operand prep, a*b, m = z*(-1/q), m*q,
// reduction add, correction, final add/sub) each take a new item every
// cycle unless stalled, with two reduction paths side by side.
// Reset clears all stage valid bits; the pipeline is then empty and ready.
// When the receiver stalls, a held result freezes all stages together and
// item.ready drops; no transaction is lost or repeated. Bubbles between
// items are carried through as empty stages.
// ----------------------------------------------------------------------------
module ntt_butterfly_montgomery_q31
	import nttbm_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	nttbm_in_if.sink    item,
	nttbm_out_if.source result
);

	logic  adv;
	logic  [7:1] vld;

	// stage 1 inputs
	op_t   op_in;
	logic  bad_in;
	coef_t ma_in, mb_in;

	// stage 1 registers
	op_t   op_s1;
	logic  bad_s1;
	coef_t u_s1, sum_s1, ma_s1, mb_s1, na_s1, nb_s1;

	// stage 2 registers
	op_t   op_s2;
	logic  bad_s2;
	coef_t u_s2, sum_s2;
	prod_t z0_s2, z1_s2;

	// stage 3 registers
	op_t   op_s3;
	logic  bad_s3;
	coef_t u_s3, sum_s3;
	prod_t z0_s3, z1_s3;
	logic  [31:0] m0_s3, m1_s3;
	logic  [63:0] mprod0, mprod1;

	// stage 4 registers
	op_t   op_s4;
	logic  bad_s4;
	coef_t u_s4, sum_s4;
	prod_t z0_s4, z1_s4;
	logic  [62:0] mq0_s4, mq1_s4;

	// stage 5 registers
	op_t   op_s5;
	logic  bad_s5;
	coef_t u_s5, sum_s5;
	logic  [31:0] t0_s5, t1_s5;
	logic  [63:0] acc0, acc1;

	// stage 6 registers
	op_t   op_s6;
	logic  bad_s6;
	coef_t u_s6, sum_s6, p0_s6, p1_s6;

	// stage 7 registers
	coef_t r0_s7, r1_s7;
	logic  bad_s7;
	coef_t r0_nx, r1_nx;

	assign adv = !vld[7] || result.ready;
	assign item.ready = adv;

	assign op_in  = op_t'(item.opcode);
	assign bad_in = (item.first_operand >= QMOD) || (item.second_operand >= QMOD)
		|| (op_in != OP_MUL && item.third_operand >= QMOD)
		|| (op_in == OP_MAC && item.fourth_operand >= QMOD);

	always_comb begin
		case (op_in)
			OP_FWD: begin
				ma_in = item.second_operand;
				mb_in = item.third_operand;
			end
			OP_INV: begin
				ma_in = mod_sub(item.first_operand, item.second_operand);
				mb_in = item.third_operand;
			end
			default: begin
				ma_in = item.first_operand;
				mb_in = item.second_operand;
			end
		endcase
	end

	assign mprod0 = {32'd0, z0_s2[31:0]} * {32'd0, QNEGINV};
	assign mprod1 = {32'd0, z1_s2[31:0]} * {32'd0, QNEGINV};
	assign acc0   = {2'b00, z0_s4} + {1'b0, mq0_s4};
	assign acc1   = {2'b00, z1_s4} + {1'b0, mq1_s4};

	always_comb begin
		case (op_s6)
			OP_FWD: begin
				r0_nx = mod_add(u_s6, p0_s6);
				r1_nx = mod_sub(u_s6, p0_s6);
			end
			OP_INV: begin
				r0_nx = sum_s6;
				r1_nx = p0_s6;
			end
			OP_MUL: begin
				r0_nx = p0_s6;
				r1_nx = '0;
			end
			OP_MAC: begin
				r0_nx = mod_add(p0_s6, p1_s6);
				r1_nx = '0;
			end
			default: begin
				r0_nx = '0;
				r1_nx = '0;
			end
		endcase
		if (bad_s6) begin
			r0_nx = '0;
			r1_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[6:1], item.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= op_in;
			bad_s1 <= bad_in;
			u_s1   <= item.first_operand;
			sum_s1 <= mod_add(item.first_operand, item.second_operand);
			ma_s1  <= ma_in;
			mb_s1  <= mb_in;
			na_s1  <= item.third_operand;
			nb_s1  <= item.fourth_operand;

			op_s2  <= op_s1;
			bad_s2 <= bad_s1;
			u_s2   <= u_s1;
			sum_s2 <= sum_s1;
			z0_s2  <= {31'd0, ma_s1} * {31'd0, mb_s1};
			z1_s2  <= {31'd0, na_s1} * {31'd0, nb_s1};

			op_s3  <= op_s2;
			bad_s3 <= bad_s2;
			u_s3   <= u_s2;
			sum_s3 <= sum_s2;
			z0_s3  <= z0_s2;
			z1_s3  <= z1_s2;
			m0_s3  <= mprod0[31:0];
			m1_s3  <= mprod1[31:0];

			op_s4  <= op_s3;
			bad_s4 <= bad_s3;
			u_s4   <= u_s3;
			sum_s4 <= sum_s3;
			z0_s4  <= z0_s3;
			z1_s4  <= z1_s3;
			mq0_s4 <= {31'd0, m0_s3} * {32'd0, QMOD};
			mq1_s4 <= {31'd0, m1_s3} * {32'd0, QMOD};

			op_s5  <= op_s4;
			bad_s5 <= bad_s4;
			u_s5   <= u_s4;
			sum_s5 <= sum_s4;
			t0_s5  <= acc0[63:32];
			t1_s5  <= acc1[63:32];

			op_s6  <= op_s5;
			bad_s6 <= bad_s5;
			u_s6   <= u_s5;
			sum_s6 <= sum_s5;
			p0_s6  <= mont_fix(t0_s5);
			p1_s6  <= mont_fix(t1_s5);

			r0_s7  <= r0_nx;
			r1_s7  <= r1_nx;
			bad_s7 <= bad_s6;
		end
	end

	assign result.valid         = vld[7];
	assign result.first_result  = r0_s7;
	assign result.second_result = r1_s7;
	assign result.range_error   = bad_s7;

endmodule
`default_nettype wire

// ----- sv/nttbm_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nttbm_props
// Port-level checks on the Montgomery NTT butterfly, bound to the top level.
// ----------------------------------------------------------------------------
module nttbm_props
	import nttbm_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [30:0] first_result,
	input wire [30:0] second_result,
	input wire        range_error
);

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_result)
			&& $stable(second_result) && $stable(range_error))
		else $error("result changed while stalled");

	// empty output stage never blocks the operand channel
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("item not ready with free output stage");

	// a range error zeroes both results
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> first_result == '0 && second_result == '0)
		else $error("nonzero result with range error");

	// results are fully reduced
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> first_result < QMOD && second_result < QMOD)
		else $error("result not below modulus");

endmodule

bind ntt_butterfly_montgomery_q31 nttbm_props u_nttbm_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (item.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.first_result  (result.first_result),
	.second_result (result.second_result),
	.range_error   (result.range_error)
);
`default_nettype wire

// ----- dv/nttbm_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nttbm_checker
// Watches the operand and result channels of the Montgomery NTT butterfly,
// computes the expected residues and range flag for every operand
// transaction, and compares them in order with every result transaction.
// ----------------------------------------------------------------------------
module nttbm_checker
	import nttbm_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	nttbm_in_if  item,
	nttbm_out_if result,
	output int   fail_count,
	output int   pending,
	output int   flagged
);

	typedef struct packed {
		coef_t first_result;
		coef_t second_result;
		logic  range_error;
	} bfly_res_t;

	bfly_res_t butterfly_results_q[$];
	bfly_res_t want;

	function automatic coef_t add_q(input coef_t a, input coef_t b);
		logic [31:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= QMOD_32) begin
			s = s - QMOD_32;
		end
		return s[COEF_W-1:0];
	endfunction

	function automatic coef_t sub_q(input coef_t a, input coef_t b);
		logic [31:0] s;
		if (a >= b) begin
			s = {1'b0, a} - {1'b0, b};
		end else begin
			s = {1'b0, a} + QMOD_32 - {1'b0, b};
		end
		return s[COEF_W-1:0];
	endfunction

	// a * b * 2^-32 mod q
	function automatic coef_t mont_prod(input coef_t a, input coef_t b);
		logic [63:0] z;
		logic [63:0] t;
		logic [31:0] m;
		logic [31:0] h;
		z = {33'd0, a} * {33'd0, b};
		m = z[31:0] * QNEGINV;
		t = z + {32'd0, m} * {32'd0, QMOD_32};
		h = t[63:32];
		if (h >= QMOD_32) begin
			h = h - QMOD_32;
		end
		return h[COEF_W-1:0];
	endfunction

	function automatic bfly_res_t butterfly_result(input op_t op, input coef_t u,
			input coef_t v, input coef_t w, input coef_t x);
		bfly_res_t r;
		coef_t     t;
		r = '0;
		r.range_error = (u >= QMOD) || (v >= QMOD) || (op != OP_MUL && w >= QMOD) ||
			(op == OP_MAC && x >= QMOD);
		if (!r.range_error) begin
			case (op)
				OP_FWD: begin
					t = mont_prod(v, w);
					r.first_result  = add_q(u, t);
					r.second_result = sub_q(u, t);
				end
				OP_INV: begin
					r.first_result  = add_q(u, v);
					r.second_result = mont_prod(sub_q(u, v), w);
				end
				OP_MUL: begin
					r.first_result = mont_prod(u, v);
				end
				default: begin
					r.first_result = add_q(mont_prod(u, v), mont_prod(w, x));
				end
			endcase
		end
		return r;
	endfunction

	task automatic check_field(input string name, input coef_t exp_val, input coef_t act_val);
		if (act_val !== exp_val) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val,
				act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			butterfly_results_q.delete();
			fail_count = 0;
			pending    = 0;
			flagged    = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (butterfly_results_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected transaction: expected none, actual %h %h %b",
						$time, result.first_result, result.second_result,
						result.range_error);
				end else begin
					want = butterfly_results_q.pop_front();
					if (want.range_error) begin
						flagged++;
					end
					check_field("first_result", want.first_result, result.first_result);
					check_field("second_result", want.second_result, result.second_result);
					check_field("range_error", coef_t'(want.range_error),
						coef_t'(result.range_error));
				end
			end
			if (item.valid && item.ready) begin
				butterfly_results_q.push_back(butterfly_result(op_t'(item.opcode),
					item.first_operand, item.second_operand, item.third_operand,
					item.fourth_operand));
			end
			pending = butterfly_results_q.size();
		end
	end

endmodule

// ----- dv/tb_ntt_butterfly_montgomery_q31.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ntt_butterfly_montgomery_q31
// Drives directed and random butterfly, product and multiply-add operations,
// in and out of range, into the Montgomery NTT unit with random idling on
// both channels and long receiver stalls; a checker compares every result.
// ----------------------------------------------------------------------------
module tb_ntt_butterfly_montgomery_q31;
	import nttbm_pkg::*;

	localparam int RANDOM_ITEMS = 1750;
	localparam int IDLE_LIMIT   = 3000;
	localparam logic [31:0] OVER_SPAN = 32'h7FFF_FFFF - QMOD_32;
	localparam coef_t Q_M1 = QMOD - 31'd1;
	localparam coef_t ONES = 31'h7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hold_off = 1'b0;
	int   source_mode = 0;
	int   sink_mode = 0;
	int   sent = 0;
	int   op_seen[4] = '{0, 0, 0, 0};
	int   idle_cycles = 0;
	int   fail_count;
	int   pending;
	int   flagged;

	nttbm_in_if  item();
	nttbm_out_if result();

	ntt_butterfly_montgomery_q31 i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	nttbm_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending),
		.flagged    (flagged)
	);

	always #6 clk = ~clk;

	function automatic int draw_wait(input int mode);
		case (mode)
			0:       return 0;
			1:       return $urandom_range(16, 0);
			default: return ($urandom_range(3, 0) == 0) ? $urandom_range(16, 0) : 0;
		endcase
	endfunction

	function automatic coef_t rand_operand();
		case ($urandom_range(31, 0))
			0:       return coef_t'(QMOD_32 + $urandom_range(OVER_SPAN, 0));
			1:       return ($urandom_range(1, 0) == 1) ? Q_M1 : coef_t'(0);
			2:       return ($urandom_range(1, 0) == 1) ? Q_M1 - 31'd1 : coef_t'(1);
			default: return coef_t'($urandom_range(QMOD_32 - 1, 0));
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_item(input op_t op, input coef_t a, input coef_t b, input coef_t c,
			input coef_t d);
		int gap;
		gap = hold_off ? 0 : draw_wait(source_mode);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.valid          <= 1'b1;
		item.opcode         <= op;
		item.first_operand  <= a;
		item.second_operand <= b;
		item.third_operand  <= c;
		item.fourth_operand <= d;
		do @(posedge clk); while (!item.ready);
		@(negedge clk);
		sent++;
		op_seen[op]++;
		if (sent % 64 == 0) begin
			source_mode = $urandom_range(2, 0);
		end
	endtask

	// watchdog
	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : receiver
		int w;
		int got;
		got = 0;
		result.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (got == 200 || got == 1100) begin
				w = 160;
				hold_off <= 1'b1;
			end else begin
				w = draw_wait(sink_mode);
			end
			if (w > 0) begin
				result.ready <= 1'b0;
				repeat (w) @(negedge clk);
				hold_off <= 1'b0;
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
			got++;
			if (got % 64 == 0) begin
				sink_mode = $urandom_range(2, 0);
			end
			@(negedge clk);
		end
	end

	initial begin : stimulus
		op_t op;
		item.valid          = 1'b0;
		item.opcode         = OP_FWD;
		item.first_operand  = '0;
		item.second_operand = '0;
		item.third_operand  = '0;
		item.fourth_operand = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extremes of each operation
		send_item(OP_FWD, 0, 0, 0, 0);
		send_item(OP_FWD, Q_M1, Q_M1, Q_M1, 0);
		send_item(OP_FWD, 0, Q_M1, 1, ONES);
		send_item(OP_INV, Q_M1, Q_M1, Q_M1, 0);
		send_item(OP_INV, 0, Q_M1, 1, ONES);
		send_item(OP_INV, 1, 0, Q_M1, 0);
		send_item(OP_MUL, Q_M1, Q_M1, ONES, ONES);
		send_item(OP_MUL, 1, 1, 0, 0);
		send_item(OP_MUL, 0, Q_M1, 0, 0);
		send_item(OP_MAC, Q_M1, Q_M1, Q_M1, Q_M1);
		send_item(OP_MAC, 0, 0, 0, 0);
		send_item(OP_MAC, 1, Q_M1, Q_M1, 1);
		// operands at or above the modulus
		send_item(OP_FWD, QMOD, 5, 7, 0);
		send_item(OP_INV, 3, QMOD, 7, 0);
		send_item(OP_FWD, 3, 5, ONES, 0);
		send_item(OP_INV, ONES, ONES, ONES, ONES);
		send_item(OP_MUL, ONES, 2, 0, 0);
		send_item(OP_MUL, 2, QMOD, 0, 0);
		send_item(OP_MAC, 2, 3, QMOD, 4);
		send_item(OP_MAC, 2, 3, 4, QMOD);
		send_item(OP_MAC, 2, 3, 4, ONES);

		repeat (RANDOM_ITEMS) begin
			op = op_t'($urandom_range(3, 0));
			send_item(op, rand_operand(), rand_operand(), rand_operand(), rand_operand());
		end
		item.valid <= 1'b0;

		wait (pending == 0);
		repeat (20) @(posedge clk);
		$display("covered %0d transactions: %0d forward, %0d inverse, %0d product, %0d mac",
			sent, op_seen[OP_FWD], op_seen[OP_INV], op_seen[OP_MUL], op_seen[OP_MAC]);
		$display("%0d flagged out of range, two long receiver stalls, %0d mismatches",
			flagged, fail_count);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
